/* hw/rtl/cssp_pkg.sv */
// shared types, constants and the named-colour table for the css colour parser
// no dependencies; used by every module in hw/rtl
package cssp_pkg;

  localparam int TEXT_CAP   = 96;
  localparam int CNT_W      = $clog2(TEXT_CAP);
  localparam int HEAD_LEN   = 7;
  localparam int NAME_COUNT = 20;

  localparam logic [CNT_W-1:0] KEEP_MAX = CNT_W'(TEXT_CAP - 1);
  localparam logic [8:0]       NO_DIGIT = 9'h1FF;

  typedef enum logic [2:0] {
    PH_PREFIX = 3'd0,
    PH_RED    = 3'd1,
    PH_GREEN  = 3'd2,
    PH_BLUE   = 3'd3,
    PH_DONE   = 3'd4,
    PH_FAIL   = 3'd5
  } phase_t;

  typedef logic [0:HEAD_LEN-1][7:0] head_t;

  typedef struct packed {
    logic [CNT_W-1:0] kept_count;
    head_t            head_chars;
    logic [7:0]       last_kept_char;
    phase_t           rgb_phase;
    logic [8:0]       digit_accum;
    logic [7:0]       red_part;
    logic [7:0]       green_part;
  } cssp_state_t;

  localparam cssp_state_t ST_RESET = '{
    kept_count:     '0,
    head_chars:     '0,
    last_kept_char: '0,
    rgb_phase:      PH_PREFIX,
    digit_accum:    '0,
    red_part:       '0,
    green_part:     '0
  };

  typedef struct packed {
    logic [2:0]  len;
    head_t       text;
    logic [23:0] rgb;
  } color_name_t;

  localparam color_name_t NAMES [NAME_COUNT] = '{
    '{3'd5, {"black",   16'h0}, 24'h000000},
    '{3'd5, {"white",   16'h0}, 24'hFFFFFF},
    '{3'd3, {"red",     32'h0}, 24'hFF0000},
    '{3'd5, {"green",   16'h0}, 24'h008000},
    '{3'd4, {"blue",    24'h0}, 24'h0000FF},
    '{3'd6, {"yellow",   8'h0}, 24'hFFFF00},
    '{3'd7, {"magenta"       }, 24'hFF00FF},
    '{3'd7, {"fuchsia"       }, 24'hFF00FF},
    '{3'd4, {"cyan",    24'h0}, 24'h00FFFF},
    '{3'd4, {"aqua",    24'h0}, 24'h00FFFF},
    '{3'd4, {"gray",    24'h0}, 24'h808080},
    '{3'd4, {"grey",    24'h0}, 24'h808080},
    '{3'd6, {"silver",   8'h0}, 24'hC0C0C0},
    '{3'd6, {"orange",   8'h0}, 24'hFFA500},
    '{3'd6, {"purple",   8'h0}, 24'h800080},
    '{3'd4, {"navy",    24'h0}, 24'h000080},
    '{3'd4, {"teal",    24'h0}, 24'h008080},
    '{3'd4, {"lime",    24'h0}, 24'h00FF00},
    '{3'd6, {"maroon",   8'h0}, 24'h800000},
    '{3'd5, {"olive",   16'h0}, 24'h808000}
  };

endpackage

/* hw/rtl/cssp_char_update.sv */
// per-character state update: blank drop, case fold, head capture, rgb() digits
// depends on cssp_pkg
module cssp_char_update (
  input  cssp_pkg::cssp_state_t st,
  input  logic [7:0]            char_code,
  output cssp_pkg::cssp_state_t st_next
);

  logic       blank;
  logic       keep;
  logic [7:0] c;
  logic       digit;
  logic [3:0] dval;
  logic [8:0] acc_base;
  logic [11:0] acc;

  assign blank = (char_code == 8'h20) || (char_code == 8'h09) || (char_code == 8'h0D) ||
                 (char_code == 8'h0A) || (char_code == 8'h0C) || (char_code == 8'h0B);
  assign keep  = !blank && (st.kept_count < cssp_pkg::KEEP_MAX);
  assign c     = ((char_code >= 8'h41) && (char_code <= 8'h5A)) ? char_code + 8'd32 : char_code;
  assign digit = (c >= 8'h30) && (c <= 8'h39);
  assign dval  = 4'(c - 8'h30);
  assign acc_base = (st.digit_accum == cssp_pkg::NO_DIGIT) ? 9'd0 : st.digit_accum;
  assign acc   = {acc_base, 3'b000} + {2'b00, acc_base, 1'b0} + {8'd0, dval};

  always_comb begin
    st_next = st;
    if (keep) begin
      if (st.kept_count < cssp_pkg::CNT_W'(cssp_pkg::HEAD_LEN)) begin
        st_next.head_chars[st.kept_count[2:0]] = c;
      end
      st_next.last_kept_char = c;
      st_next.kept_count     = st.kept_count + cssp_pkg::CNT_W'(1);
      if (st.kept_count == cssp_pkg::CNT_W'(3)) begin
        st_next.rgb_phase   = cssp_pkg::PH_RED;
        st_next.digit_accum = cssp_pkg::NO_DIGIT;
      end else if (st.kept_count > cssp_pkg::CNT_W'(3)) begin
        unique case (st.rgb_phase)
          cssp_pkg::PH_RED, cssp_pkg::PH_GREEN, cssp_pkg::PH_BLUE: begin
            if (digit) begin
              if (acc > 12'd255) st_next.rgb_phase = cssp_pkg::PH_FAIL;
              else st_next.digit_accum = acc[8:0];
            end else if (st.digit_accum == cssp_pkg::NO_DIGIT) begin
              st_next.rgb_phase = cssp_pkg::PH_FAIL;
            end else if (st.rgb_phase == cssp_pkg::PH_BLUE) begin
              st_next.rgb_phase = cssp_pkg::PH_DONE;
            end else if (c == 8'h2C) begin
              if (st.rgb_phase == cssp_pkg::PH_RED) begin
                st_next.red_part  = st.digit_accum[7:0];
                st_next.rgb_phase = cssp_pkg::PH_GREEN;
              end else begin
                st_next.green_part = st.digit_accum[7:0];
                st_next.rgb_phase  = cssp_pkg::PH_BLUE;
              end
              st_next.digit_accum = cssp_pkg::NO_DIGIT;
            end else begin
              st_next.rgb_phase = cssp_pkg::PH_FAIL;
            end
          end
          cssp_pkg::PH_PREFIX, cssp_pkg::PH_DONE: ;
          default: st_next.rgb_phase = cssp_pkg::PH_FAIL;
        endcase
      end
    end
  end

endmodule

/* hw/rtl/cssp_judge.sv */
// end-of-value decision: hex forms, rgb() form and named colour lookup
// depends on cssp_pkg
module cssp_judge (
  input  cssp_pkg::cssp_state_t st,
  output logic                  parsed_ok,
  output logic [23:0]           rgb_value
);

  // 16 flags a byte that is not a lower-case hex digit
  function automatic logic [4:0] nibble_of(input logic [7:0] ch);
    logic [4:0] r;
    if ((ch >= 8'h30) && (ch <= 8'h39)) r = 5'(ch - 8'h30);
    else if ((ch >= 8'h61) && (ch <= 8'h66)) r = 5'(ch - 8'h57);
    else r = 5'd16;
    return r;
  endfunction

  logic [4:0] nb [6];
  logic       hex3_ok;
  logic       hex6_ok;
  logic       is_rgb;
  logic       name_hit;
  logic [23:0] name_rgb;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      nb[i] = nibble_of(st.head_chars[i+1]);
    end
  end

  assign hex3_ok = !nb[0][4] && !nb[1][4] && !nb[2][4];
  assign hex6_ok = hex3_ok && !nb[3][4] && !nb[4][4] && !nb[5][4];
  assign is_rgb  = (st.kept_count >= cssp_pkg::CNT_W'(6)) && (st.head_chars[0] == 8'h72) &&
                   (st.head_chars[1] == 8'h67) && (st.head_chars[2] == 8'h62) &&
                   (st.head_chars[3] == 8'h28) && (st.last_kept_char == 8'h29);

  // unwritten head slots stay zero, so a full compare matches the padded table
  always_comb begin
    name_hit = 1'b0;
    name_rgb = '0;
    for (int i = cssp_pkg::NAME_COUNT - 1; i >= 0; i--) begin
      if ((st.kept_count == cssp_pkg::CNT_W'(cssp_pkg::NAMES[i].len)) &&
          (st.head_chars == cssp_pkg::NAMES[i].text)) begin
        name_hit = 1'b1;
        name_rgb = cssp_pkg::NAMES[i].rgb;
      end
    end
  end

  always_comb begin
    parsed_ok = 1'b0;
    rgb_value = '0;
    if (st.kept_count == '0) begin
      parsed_ok = 1'b0;
    end else if (st.head_chars[0] == 8'h23) begin
      if ((st.kept_count == cssp_pkg::CNT_W'(4)) && hex3_ok) begin
        parsed_ok = 1'b1;
        rgb_value = {nb[0][3:0], nb[0][3:0], nb[1][3:0], nb[1][3:0], nb[2][3:0], nb[2][3:0]};
      end else if ((st.kept_count == cssp_pkg::CNT_W'(7)) && hex6_ok) begin
        parsed_ok = 1'b1;
        rgb_value = {nb[0][3:0], nb[1][3:0], nb[2][3:0], nb[3][3:0], nb[4][3:0], nb[5][3:0]};
      end
    end else if (is_rgb) begin
      if (st.rgb_phase == cssp_pkg::PH_DONE) begin
        parsed_ok = 1'b1;
        rgb_value = {st.red_part, st.green_part, st.digit_accum[7:0]};
      end
    end else if (name_hit) begin
      parsed_ok = 1'b1;
      rgb_value = name_rgb;
    end
  end

endmodule

/* hw/rtl/css_color_value_parser_top.sv */
// a character transfer is registered in the input register, then processed into the
// parse-state register; a last character's result is loaded into the result register
// throughput: one character per cycle, set by the single-pass update between the
// input register and the parse-state register; output stalls back up through ready
// reset (rst, synchronous, active high) empties both registers and clears parse state
// top level: stream handshake, input and result registers, parse state register
module css_color_value_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tlast,   // is_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [23:0] rgb_value
  output logic        m_tuser    // parsed_ok
);

  // input register
  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_last;

  // parse state carried between characters of one value
  cssp_pkg::cssp_state_t st;
  cssp_pkg::cssp_state_t st_next;

  logic        out_free;
  logic        s1_consume;
  logic        judge_ok;
  logic [23:0] judge_rgb;

  // a non-final character never needs the output slot
  assign out_free   = !m_tvalid || m_tready;
  assign s1_consume = s1_valid && (!s1_last || out_free);
  assign s_tready   = !s1_valid || s1_consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      s1_valid <= 1'b1;
    end else if (s1_consume) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_char <= s_tdata;
      s1_last <= s_tlast;
    end
  end

  cssp_char_update u_update (
    .st        (st),
    .char_code (s1_char),
    .st_next   (st_next)
  );

  // judged on the state including the final character
  cssp_judge u_judge (
    .st        (st_next),
    .parsed_ok (judge_ok),
    .rgb_value (judge_rgb)
  );

  // state returns to its reset value after each value's last character
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= cssp_pkg::ST_RESET;
    end else if (s1_consume) begin
      st <= s1_last ? cssp_pkg::ST_RESET : st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_consume && s1_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_consume && s1_last) begin
      m_tdata <= judge_rgb;
      m_tuser <= judge_ok;
    end
  end

`ifndef SYNTH
  a_invalid_is_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == 24'd0))
    else $error("rejected value carries a non-zero colour");

  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    (s1_consume && s1_last) |=> (st.kept_count == '0))
    else $error("parse state not cleared after last character");

  a_count_capped: assert property (@(posedge clk) disable iff (rst)
    st.kept_count <= cssp_pkg::KEEP_MAX)
    else $error("kept character count beyond cap");

  a_phase_after_prefix: assert property (@(posedge clk) disable iff (rst)
    (st.rgb_phase != cssp_pkg::PH_PREFIX) |-> (st.kept_count >= cssp_pkg::CNT_W'(4)))
    else $error("rgb phase left prefix before four characters kept");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    (s1_consume && s1_last) |-> out_free)
    else $error("result register loaded while holding an untaken result");
`endif

endmodule

/* test/tb_css_color_value_parser_top.sv */
`timescale 1ns / 1ps
// self-checking bench for css_color_value_parser_top: directed and random colour text
// depends on cssp_pkg and the parser rtl; a built-in colour predictor scores every result

module tb_css_color_value_parser_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int CHAR_TARGET = 1600;
  localparam int CALM_TAIL   = 250;   // closing transfers run without any idling

  localparam logic [7:0] BLANKS [6] = '{8'h20, 8'h09, 8'h0D, 8'h0A, 8'h0C, 8'h0B};

  // tracks the parse of the current value and queues the colour it should give
  class colour_scoreboard;
    typedef struct packed {
      logic        ok;
      logic [23:0] rgb;
    } colour_t;

    string       names [cssp_pkg::NAME_COUNT];
    logic [23:0] name_rgb [cssp_pkg::NAME_COUNT];

    int unsigned       kept;
    logic [7:0]        head [cssp_pkg::HEAD_LEN];
    logic [7:0]        last_ch;
    cssp_pkg::phase_t  phase;
    logic [8:0]        accum;
    logic [7:0]        red;
    logic [7:0]        green;

    colour_t     pending_colours [$];
    int          errors;
    int          checked;
    int          recognised;
    int          chars_seen;
    int          values_seen;

    function new();
      names    = '{"black", "white", "red", "green", "blue", "yellow", "magenta",
                   "fuchsia", "cyan", "aqua", "gray", "grey", "silver", "orange",
                   "purple", "navy", "teal", "lime", "maroon", "olive"};
      name_rgb = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h008000, 24'h0000FF,
                   24'hFFFF00, 24'hFF00FF, 24'hFF00FF, 24'h00FFFF, 24'h00FFFF,
                   24'h808080, 24'h808080, 24'hC0C0C0, 24'hFFA500, 24'h800080,
                   24'h000080, 24'h008080, 24'h00FF00, 24'h800000, 24'h808000};
      errors      = 0;
      checked     = 0;
      recognised  = 0;
      chars_seen  = 0;
      values_seen = 0;
      clear_state();
    endfunction

    function void clear_state();
      kept = 0;
      foreach (head[i]) head[i] = 8'h00;
      last_ch = 8'h00;
      phase   = cssp_pkg::PH_PREFIX;
      accum   = 9'h000;
      red     = 8'h00;
      green   = 8'h00;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A || c == 8'h0C ||
             c == 8'h0B;
    endfunction

    // 16 flags a byte that is not a lower-case hex digit
    function int nibble(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      return 16;
    endfunction

    // decimal component tracking for the rgb(...) form
    function void advance_rgb(logic [7:0] c);
      int acc;
      if (phase == cssp_pkg::PH_PREFIX || phase == cssp_pkg::PH_DONE ||
          phase == cssp_pkg::PH_FAIL) return;
      if (c >= "0" && c <= "9") begin
        acc = (accum == cssp_pkg::NO_DIGIT) ? 0 : int'(accum);
        acc = acc * 10 + int'(c - "0");
        if (acc > 255) phase = cssp_pkg::PH_FAIL;
        else accum = acc[8:0];
      end else if (accum == cssp_pkg::NO_DIGIT) begin
        phase = cssp_pkg::PH_FAIL;
      end else if (phase == cssp_pkg::PH_BLUE) begin
        phase = cssp_pkg::PH_DONE;
      end else if (c == ",") begin
        if (phase == cssp_pkg::PH_RED) red = accum[7:0];
        else green = accum[7:0];
        phase = (phase == cssp_pkg::PH_RED) ? cssp_pkg::PH_GREEN : cssp_pkg::PH_BLUE;
        accum = cssp_pkg::NO_DIGIT;
      end else begin
        phase = cssp_pkg::PH_FAIL;
      end
    endfunction

    function colour_t predict_colour();
      colour_t    res;
      logic [3:0] nib [6];
      int         v;
      int         i;
      int         j;
      bit         same;
      res = '0;
      if (kept == 0) return res;
      if (head[0] == "#") begin
        if (kept != 4 && kept != 7) return res;
        for (i = 0; i < int'(kept) - 1; i++) begin
          v = nibble(head[i + 1]);
          if (v > 15) return res;
          nib[i] = v[3:0];
        end
        if (kept == 4) res.rgb = {nib[0], nib[0], nib[1], nib[1], nib[2], nib[2]};
        else res.rgb = {nib[0], nib[1], nib[2], nib[3], nib[4], nib[5]};
        res.ok = 1'b1;
        return res;
      end
      if (kept >= 6 && head[0] == "r" && head[1] == "g" && head[2] == "b" &&
          head[3] == "(" && last_ch == ")") begin
        if (phase == cssp_pkg::PH_DONE) res = {1'b1, red, green, accum[7:0]};
        return res;
      end
      for (i = 0; i < cssp_pkg::NAME_COUNT; i++) begin
        if (names[i].len() == int'(kept)) begin
          same = 1'b1;
          for (j = 0; j < int'(kept); j++) if (head[j] != names[i][j]) same = 1'b0;
          if (same) begin
            res.ok  = 1'b1;
            res.rgb = name_rgb[i];
            return res;
          end
        end
      end
      return res;
    endfunction

    function void note_char(logic [7:0] raw, logic is_last);
      logic [7:0] c;
      c = raw;
      chars_seen++;
      if (!is_blank(c) && kept + 1 < cssp_pkg::TEXT_CAP) begin
        if (c >= "A" && c <= "Z") c = c + 8'd32;
        if (kept < cssp_pkg::HEAD_LEN) head[kept] = c;
        last_ch = c;
        if (kept == 3) begin
          phase = cssp_pkg::PH_RED;
          accum = cssp_pkg::NO_DIGIT;
        end else if (kept > 3) begin
          advance_rgb(c);
        end
        kept++;
      end
      if (is_last) begin
        pending_colours.push_back(predict_colour());
        values_seen++;
        clear_state();
      end
    endfunction

    function void check_result(logic ok, logic [23:0] rgb);
      colour_t want;
      if (pending_colours.size() == 0) begin
        $error("unexpected result: parsed_ok %0d rgb_value %06h", ok, rgb);
        errors++;
        return;
      end
      want = pending_colours.pop_front();
      checked++;
      if (want.ok) recognised++;
      if (ok !== want.ok) begin
        $error("parsed_ok: expected %0d, actual %0d", want.ok, ok);
        errors++;
      end
      if (rgb !== want.rgb) begin
        $error("rgb_value: expected %06h, actual %06h", want.rgb, rgb);
        errors++;
      end
    endfunction

    function int pending();
      return pending_colours.size();
    endfunction
  endclass

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;   // [7:0] char_code
  logic        s_tlast  = 1'b0;    // is_last
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;            // [23:0] rgb_value
  logic        m_tuser;            // parsed_ok

  colour_scoreboard sb = new();

  logic [7:0] text_q [$];          // characters of the value being built
  bit         source_idle = 1'b0;
  bit         sink_idle   = 1'b0;
  int         stall_left  = 0;
  int         chars_sent  = 0;
  int         cycles      = 0;

  css_color_value_parser_top u_top (
    .clk,
    .rst,
    .s_tvalid,
    .s_tready,
    .s_tdata,
    .s_tlast,
    .m_tvalid,
    .m_tready,
    .m_tdata,
    .m_tuser
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random ready stalls, timed by stall_left, while sink idling is enabled
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (sink_idle && $urandom_range(0, 5) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // both monitors sample at the edge, before any of this edge's updates land
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_char(s_tdata, s_tlast);
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
  end

  // one character transfer; an optional gap goes in front of it
  task automatic send_char(input logic [7:0] code, input logic is_last);
    if (source_idle && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= code;
    s_tlast  <= is_last;
    do @(posedge clk); while (!s_tready);
    chars_sent++;
  endtask

  task automatic send_value();
    foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic send_text(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_value();
  endtask

  task automatic send_one(input logic [7:0] c);
    text_q.delete();
    text_q.push_back(c);
    send_value();
  endtask

  // hold the sender off until every queued colour has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [7:0] hex_char(input int v);
    return (v < 10) ? 8'(v + 48) : 8'(v + 87);
  endfunction

  // appends a character with random case and the odd blank in front
  function automatic void put(input logic [7:0] c);
    logic [7:0] ch;
    ch = c;
    if ($urandom_range(0, 9) == 0) text_q.push_back(BLANKS[$urandom_range(0, 5)]);
    if (ch >= "a" && ch <= "z" && $urandom_range(0, 1) == 1) ch = ch - 8'd32;
    text_q.push_back(ch);
  endfunction

  function automatic void put_str(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endfunction

  function automatic void put_hex(input int n);
    for (int i = 0; i < n; i++) put(hex_char($urandom_range(0, 15)));
  endfunction

  function automatic void put_num(input int v);
    if ($urandom_range(0, 7) == 0) put("0");
    put_str($sformatf("%0d", v));
  endfunction

  function automatic int component();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // mostly well-formed colours with random content, then broken forms and noise
  function automatic void build_value();
    int    pick;
    int    n;
    int    sub;
    string s;
    text_q.delete();
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      put("#");
      put_hex(3);
    end else if (pick < 30) begin
      put("#");
      put_hex(6);
    end else if (pick < 50) begin
      put_str("rgb(");
      put_num(component());
      put(",");
      put_num(component());
      put(",");
      put_num(component());
      // trailing junk before the closing parenthesis is tolerated
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) put(8'($urandom_range(33, 126)));
      put(")");
    end else if (pick < 68) begin
      put_str(sb.names[$urandom_range(0, cssp_pkg::NAME_COUNT - 1)]);
    end else if (pick < 86) begin
      case ($urandom_range(0, 6))
        0: begin
          // hash of a length other than 3 or 6 digits
          n = $urandom_range(0, 6);
          if (n >= 3) n++;
          if (n >= 6) n++;
          put("#");
          put_hex(n);
        end
        1: begin
          // one digit outside the hex range
          n   = ($urandom_range(0, 1) == 1) ? 3 : 6;
          sub = $urandom_range(0, n - 1);
          put("#");
          for (int i = 0; i < n; i++) begin
            if (i == sub) put(8'($urandom_range(103, 122)));
            else put(hex_char($urandom_range(0, 15)));
          end
        end
        2: begin
          // one component above 255
          sub = $urandom_range(0, 2);
          put_str("rgb(");
          for (int i = 0; i < 3; i++) begin
            put_num((i == sub) ? $urandom_range(256, 999) : component());
            if (i < 2) put(",");
          end
          put(")");
        end
        3: begin
          // one component with no digits
          sub = $urandom_range(0, 2);
          put_str("rgb(");
          for (int i = 0; i < 3; i++) begin
            if (i != sub) put_num(component());
            if (i < 2) put(",");
          end
          put(")");
        end
        4: begin
          // bad separator or missing closing parenthesis
          sub = $urandom_range(0, 1);
          put_str("rgb(");
          put_num(component());
          put((sub == 0) ? ";" : ",");
          put_num(component());
          put(",");
          put_num(component());
          if (sub == 1) put(",");
          else put(")");
        end
        5: begin
          // near-miss colour name
          s = sb.names[$urandom_range(0, cssp_pkg::NAME_COUNT - 1)];
          if ($urandom_range(0, 1) == 1) begin
            put_str(s.substr(0, s.len() - 2));
          end else begin
            put_str(s);
            put(8'($urandom_range(97, 122)));
          end
        end
        default: begin
          put_str("rgba(");
          put_num(component());
          put(",");
          put_num(component());
          put(",");
          put_num(component());
          put(")");
        end
      endcase
    end else if (pick < 94) begin
      // raw bytes over the full code range
      repeat ($urandom_range(1, 12)) text_q.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 99) begin
      // only blanks, so nothing is kept
      repeat ($urandom_range(1, 3)) text_q.push_back(BLANKS[$urandom_range(0, 5)]);
    end else begin
      // overlong rgb text: the closing parenthesis lands either side of the cap
      put_str("rgb(");
      put_num(component());
      put(",");
      put_num(component());
      put(",");
      put_num(component());
      repeat ($urandom_range(78, 92)) text_q.push_back("x");
      put(")");
      repeat ($urandom_range(0, 4)) text_q.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 7) == 0) text_q.push_back(BLANKS[$urandom_range(0, 5)]);
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: each form, folding, blanks, rejects and byte extremes
    source_idle = 1'b1;
    sink_idle   = 1'b1;
    send_text("#0aF");
    send_text("#00FF80");
    send_text(" Re\td\n");
    send_text("rgb(255,0,7)");
    send_text("#12");
    send_text("rgb(300)");
    send_text("rgb(,)");
    send_one(8'h00);
    send_one(8'hFF);
    send_one(8'h0D);
    send_one(8'h0B);
    drain();

    // random values, idling switched per value, quiet towards the end
    while (chars_sent < CHAR_TARGET) begin
      source_idle = (chars_sent < CHAR_TARGET - CALM_TAIL) && ($urandom_range(0, 3) != 0);
      sink_idle   = (chars_sent < CHAR_TARGET - CALM_TAIL) && ($urandom_range(0, 3) != 0);
      build_value();
      send_value();
      if ($urandom_range(0, 39) == 0) drain();
    end
    drain();
    repeat (8) @(posedge clk);

    $display("covered %0d character transfers in %0d colour values", sb.chars_seen,
             sb.values_seen);
    $display("%0d results checked, %0d of them recognised colours", sb.checked,
             sb.recognised);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
